// File: rtl/sll_pkg.sv
// Shared types, widths and codes for the static linked list engine.
`default_nettype none
package sll_pkg;
	localparam int NODE_COUNT_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int POS_W           = 10;
	localparam int NODE_W          = 10;
	localparam int DATA_W          = 32;
	localparam int STATUS_W        = 2;

	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [NODE_W-1:0]          node_t;
	typedef logic signed [DATA_W-1:0]   data_t;
	typedef logic [STATUS_W-1:0]        status_t;

	localparam logic    CMD_INSERT = 1'b0;
	localparam logic    CMD_DELETE = 1'b1;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_FREE = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;
endpackage
`default_nettype wire

// File: rtl/sll_if.sv
// Request and response channel interfaces of the linked list engine.
`default_nettype none
interface sll_req_if;
	import sll_pkg::*;
	logic  valid;
	logic  ready;
	logic  cmd;
	pos_t  position;
	data_t value;
	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

interface sll_rsp_if;
	import sll_pkg::*;
	logic    valid;
	logic    ready;
	status_t result_status;
	node_t   node_index;
	data_t   removed_value;
	modport source (output valid, output result_status, output node_index,
		output removed_value, input ready);
	modport sink (input valid, input result_status, input node_index,
		input removed_value, output ready);
endinterface
`default_nettype wire

// File: rtl/static_linked_list_engine_core.sv
// Top level: sequencer of the static linked list engine over link and value RAMs.
// Usage: requests arrive on req (cmd, position, value); cmd insert puts value at a
// 1-based position, cmd delete removes the node at a position. Each request gives
// exactly one response on rsp: result_status, node_index and removed_value.
// Sequence: an accepted insert passes S_FREE, S_WALK, S_INS_LINK and S_DONE, a delete
// S_WALK, S_DEL_J, S_DEL_F and S_DONE; a rejected request goes straight to S_DONE.
// The walk follows one link per cycle through the link RAM read port, so the worst
// case is an insert at the tail. One request is in flight at a time: req.ready is
// high only while the sequencer is idle and rises again in the cycle the response
// enters the output register.
// Reset: after arst_n rises the link RAM is swept once to build the free chain,
// during which req.ready stays low. The list is then empty.
// Stall: a response waits in the output register until rsp.ready; the sequencer
// may accept the next request meanwhile and holds its own result until the
// output register frees up.
`default_nettype none
module static_linked_list_engine_core #(
	parameter int NODE_COUNT  = sll_pkg::NODE_COUNT_DEF,
	parameter int VALUE_WIDTH = sll_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sll_req_if.sink    req,
	sll_rsp_if.source  rsp
);
	import sll_pkg::*;

	localparam int IW   = $clog2(NODE_COUNT);
	localparam int CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] DATA_HEAD = IW'(NODE_COUNT - 1);
	localparam logic [IW-1:0] FREE_END  = IW'(NODE_COUNT - 2);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_FREE     = 3'd2;
	localparam logic [2:0] S_WALK     = 3'd3;
	localparam logic [2:0] S_INS_LINK = 3'd4;
	localparam logic [2:0] S_DEL_J    = 3'd5;
	localparam logic [2:0] S_DEL_F    = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0]             state_q;
	logic [IW-1:0]          clr_q;
	logic [IW-1:0]          free_q;
	logic [IW-1:0]          len_q;
	logic [IW-1:0]          k_q;
	logic [IW-1:0]          j_q;
	logic [POS_W-1:0]       cnt_q;
	logic                   cmd_q;
	status_t                res_status_q;
	logic [IW-1:0]          res_node_q;
	data_t                  res_removed_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	node_t                  out_node_q;
	data_t                  out_removed_q;

	logic                   link_we, link_re;
	logic [IW-1:0]          link_waddr, link_wdata, link_raddr, link_rdata;
	logic                   val_we, val_re;
	logic [IW-1:0]          val_raddr;
	logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

	logic                   accept;
	logic [CMPW-1:0]        pos_ext, len_ext;
	logic                   ins_bad, del_bad;
	logic                   out_free;

	assign accept   = req.valid && req.ready;
	assign pos_ext  = CMPW'(req.position);
	assign len_ext  = CMPW'(len_q);
	assign ins_bad  = (req.position == '0) || (pos_ext > len_ext + CMPW'(1));
	assign del_bad  = (req.position == '0) || (pos_ext > len_ext);
	assign out_free = !out_valid_q || rsp.ready;
	assign val_wdata = VALUE_WIDTH'($unsigned(req.value));

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.result_status = out_status_q;
	assign rsp.node_index    = out_node_q;
	assign rsp.removed_value = out_removed_q;

	sll_ram #(.DEPTH(NODE_COUNT), .WIDTH(IW)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	sll_ram #(.DEPTH(NODE_COUNT), .WIDTH(VALUE_WIDTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (free_q),
		.wdata (val_wdata),
		.re    (val_re),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	always_comb begin
		link_we    = 1'b0;
		link_waddr = k_q;
		link_wdata = j_q;
		link_re    = 1'b0;
		link_raddr = DATA_HEAD;
		val_we     = 1'b0;
		val_re     = 1'b0;
		val_raddr  = link_rdata;
		case (state_q)
			S_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = (clr_q < FREE_END) ? clr_q + IW'(1) : '0;
			end
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_INSERT) begin
						if (free_q != '0 && !ins_bad) begin
							link_re    = 1'b1;
							link_raddr = free_q;
							val_we     = 1'b1;
						end
					end else if (!del_bad) begin
						link_re = 1'b1;
					end
				end
			end
			S_FREE: begin
				link_re = 1'b1;
			end
			S_WALK: begin
				if (cnt_q != '0) begin
					link_re    = 1'b1;
					link_raddr = link_rdata;
				end else if (cmd_q == CMD_INSERT) begin
					link_we    = 1'b1;
					link_waddr = j_q;
					link_wdata = link_rdata;
				end else begin
					link_re    = 1'b1;
					link_raddr = link_rdata;
					val_re     = 1'b1;
				end
			end
			S_INS_LINK: begin
				link_we = 1'b1;
			end
			S_DEL_J: begin
				link_we    = 1'b1;
				link_wdata = link_rdata;
			end
			S_DEL_F: begin
				link_we    = 1'b1;
				link_waddr = j_q;
				link_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			free_q      <= IW'(1);
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == DATA_HEAD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						if (req.cmd == CMD_INSERT) begin
							if (free_q != '0 && !ins_bad) begin
								state_q <= S_FREE;
							end
						end else if (!del_bad) begin
							state_q <= S_WALK;
						end
					end
				end
				S_FREE: begin
					free_q  <= link_rdata;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (cnt_q == '0) begin
						state_q <= (cmd_q == CMD_INSERT) ? S_INS_LINK : S_DEL_J;
					end
				end
				S_INS_LINK: begin
					len_q   <= len_q + IW'(1);
					state_q <= S_DONE;
				end
				S_DEL_J: begin
					state_q <= S_DEL_F;
				end
				S_DEL_F: begin
					free_q  <= j_q;
					len_q   <= len_q - IW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q         <= req.cmd;
				cnt_q         <= req.position - POS_W'(1);
				k_q           <= DATA_HEAD;
				j_q           <= free_q;
				res_node_q    <= '0;
				res_removed_q <= '0;
				res_status_q  <= ST_OK;
				if (req.cmd == CMD_INSERT) begin
					if (free_q == '0) begin
						res_status_q <= ST_NO_FREE;
					end else if (ins_bad) begin
						res_status_q <= ST_RANGE;
					end
				end else if (del_bad) begin
					res_status_q <= ST_RANGE;
				end
			end
			S_WALK: begin
				if (cnt_q != '0) begin
					k_q   <= link_rdata;
					cnt_q <= cnt_q - POS_W'(1);
				end else if (cmd_q == CMD_DELETE) begin
					j_q <= link_rdata;
				end
			end
			S_INS_LINK: begin
				res_node_q <= j_q;
			end
			S_DEL_F: begin
				res_node_q    <= j_q;
				res_removed_q <= DATA_W'(val_rdata);
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q  <= res_status_q;
					out_node_q    <= NODE_W'(res_node_q);
					out_removed_q <= res_removed_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/sll_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module sll_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: test/tb_static_linked_list_engine_core.sv
// Testbench for the linked list engine: random and directed inserts and deletes.
module tb_static_linked_list_engine_core;
	timeunit 1ns;
	timeprecision 1ps;
	import sll_pkg::*;

	localparam int    NODES     = NODE_COUNT_DEF;
	localparam node_t FREE_HEAD = node_t'(0);
	localparam node_t DATA_HEAD = node_t'(NODES - 1);
	localparam int    MAX_GAP   = 12;

	typedef struct packed {
		logic  cmd;
		pos_t  position;
		data_t value;
	} sll_req_t;

	typedef struct packed {
		status_t status;
		node_t   node;
		data_t   removed;
	} sll_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sll_req_if req_ch ();
	sll_rsp_if rsp_ch ();

	static_linked_list_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	node_t       link_mem [NODES];
	data_t       val_mem [NODES];
	int unsigned list_len;

	sll_req_t    pending_reqs [$];
	sll_result_t expected_rsps [$];
	int          errors = 0;
	bit          idle_on = 1'b0;
	int          send_gap = 0;
	int          rsp_hold = 0;

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	function automatic node_t walk_to(input int unsigned steps);
		node_t k;
		k = DATA_HEAD;
		repeat (steps) k = link_mem[k];
		return k;
	endfunction

	function automatic sll_result_t predict_list_op(input sll_req_t r);
		sll_result_t res;
		node_t       fresh;
		node_t       prev;
		node_t       victim;
		res.status  = ST_OK;
		res.node    = '0;
		res.removed = '0;
		if (r.cmd == CMD_INSERT) begin
			fresh = link_mem[FREE_HEAD];
			if (fresh == FREE_HEAD) begin
				res.status = ST_NO_FREE;
			end else if (r.position < 1 || int'(r.position) > int'(list_len) + 1) begin
				res.status = ST_RANGE;
			end else begin
				link_mem[FREE_HEAD] = link_mem[fresh];
				val_mem[fresh] = r.value;
				prev = walk_to(r.position - 1);
				link_mem[fresh] = link_mem[prev];
				link_mem[prev] = fresh;
				list_len++;
				res.node = fresh;
			end
		end else begin
			if (r.position < 1 || int'(r.position) > int'(list_len)) begin
				res.status = ST_RANGE;
			end else begin
				prev = walk_to(r.position - 1);
				victim = link_mem[prev];
				link_mem[prev] = link_mem[victim];
				res.removed = val_mem[victim];
				link_mem[victim] = link_mem[FREE_HEAD];
				link_mem[FREE_HEAD] = victim;
				list_len--;
				res.node = victim;
			end
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin : drv
		logic accept;
		if (arst_n) begin
			accept = req_ch.valid && req_ch.ready;
			if (accept) begin
				expected_rsps.push_back(predict_list_op(pending_reqs.pop_front()));
				send_gap = draw_gap();
			end else if (!req_ch.valid && send_gap > 0) begin
				send_gap--;
			end
			if (!req_ch.valid || accept) begin
				if (send_gap == 0 && pending_reqs.size() != 0) begin
					req_ch.valid    <= 1'b1;
					req_ch.cmd      <= pending_reqs[0].cmd;
					req_ch.position <= pending_reqs[0].position;
					req_ch.value    <= pending_reqs[0].value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin : mon
		sll_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response: status %0d node %0d removed %0d",
						$time, rsp_ch.result_status, rsp_ch.node_index,
						rsp_ch.removed_value);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.result_status !== want.status) begin
						$display("%0t: result_status expected %0d actual %0d",
							$time, want.status, rsp_ch.result_status);
						errors++;
					end
					if (rsp_ch.node_index !== want.node) begin
						$display("%0t: node_index expected %0d actual %0d",
							$time, want.node, rsp_ch.node_index);
						errors++;
					end
					if (rsp_ch.removed_value !== want.removed) begin
						$display("%0t: removed_value expected %0d actual %0d",
							$time, want.removed, rsp_ch.removed_value);
						errors++;
					end
				end
				rsp_hold = draw_gap();
			end else if (rsp_ch.valid && rsp_hold > 0) begin
				rsp_hold--;
			end
			rsp_ch.ready <= (rsp_hold == 0);
		end
	end

	task automatic wait_slot();
		while (pending_reqs.size() != 0) @(posedge clk);
	endtask

	task automatic send(input logic c, input pos_t p, input data_t v);
		sll_req_t r;
		wait_slot();
		r.cmd      = c;
		r.position = p;
		r.value    = v;
		pending_reqs.push_back(r);
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
	endtask

	function automatic pos_t pick_position(input logic c);
		int unsigned lim;
		int unsigned p;
		lim = (c == CMD_INSERT) ? list_len + 1 : list_len;
		p = $urandom_range(0, 99);
		if (p < 8) begin
			if ($urandom_range(0, 1) == 0 || lim >= 1023)
				return pos_t'(0);
			return pos_t'($urandom_range(lim + 1, 1023));
		end
		if (lim == 0)
			return pos_t'(1);
		if (p < 18)
			return pos_t'(lim);
		if (p < 75)
			return pos_t'($urandom_range(1, lim < 6 ? lim : 6));
		return pos_t'($urandom_range(1, lim));
	endfunction

	function automatic data_t pick_value();
		case ($urandom_range(0, 39))
			0: return data_t'(32'h7fff_ffff);
			1: return data_t'(32'h8000_0000);
			2: return data_t'(0);
			3: return data_t'(-1);
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic send_random(input int insert_pct);
		logic c;
		wait_slot();
		c = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
		send(c, pick_position(c), pick_value());
	endtask

	initial begin
		for (int i = 0; i < NODES; i++) begin
			link_mem[i] = node_t'(i + 1);
			val_mem[i]  = '0;
		end
		link_mem[NODES-2] = FREE_HEAD;
		link_mem[NODES-1] = FREE_HEAD;
		list_len = 0;

		req_ch.valid    = 1'b0;
		req_ch.cmd      = CMD_INSERT;
		req_ch.position = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty list and range edges
		send(CMD_DELETE, 1, 0);
		send(CMD_DELETE, 0, 0);
		send(CMD_INSERT, 0, 5);
		send(CMD_INSERT, 2, 6);
		send(CMD_INSERT, 1023, data_t'(32'h7fff_ffff));
		send(CMD_INSERT, 1, data_t'(32'h7fff_ffff));
		send(CMD_INSERT, 2, data_t'(32'h8000_0000));
		send(CMD_INSERT, 1, 0);
		send(CMD_INSERT, 2, -1);
		send(CMD_INSERT, 5, data_t'(32'h5555_5555));
		send(CMD_INSERT, 7, 7);
		send(CMD_DELETE, 6, 0);
		send(CMD_DELETE, 3, 0);
		send(CMD_DELETE, 4, 0);
		send(CMD_DELETE, 1, 0);
		send(CMD_INSERT, 1, data_t'(32'haaaa_aaaa));
		send(CMD_DELETE, 1023, -1);
		send(CMD_DELETE, 0, 0);
		send(CMD_DELETE, 1, 0);
		send(CMD_DELETE, 1, 0);
		send(CMD_DELETE, 1, 0);
		send(CMD_DELETE, 1, 0);
		settle();

		// mixed traffic, growing list
		for (int i = 0; i < 250; i++) begin
			if (i % 40 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			send_random(60);
		end
		settle();

		// grow the list further, then range edges at both ends
		idle_on = 1'b0;
		for (int i = 0; i < 100; i++) begin
			if (i % 25 == 0)
				idle_on = ~idle_on;
			send_random(100);
		end
		idle_on = 1'b1;
		send(CMD_INSERT, 0, 1);
		send(CMD_INSERT, 1023, 2);
		for (int i = 0; i < 4; i++)
			send_random(100);
		settle();

		// churn at the grown length
		for (int i = 0; i < 60; i++)
			send_random(50);

		// drain back down with short walks
		for (int i = 0; i < 150; i++) begin
			if (i % 50 == 0)
				idle_on = ($urandom_range(0, 1) != 0);
			send_random(30);
		end

		settle();
		repeat (NODES + 100) @(posedge clk);
		if (errors == 0)
			$display("tb_static_linked_list_engine_core: done, clean");
		else
			$display("tb_static_linked_list_engine_core: done, errors");
		$finish;
	end

	initial begin
		#80ms;
		$display("tb_static_linked_list_engine_core: done, errors");
		$finish;
	end
endmodule

// File: static_linked_list_engine_core.f
rtl/sll_pkg.sv
rtl/sll_if.sv
rtl/sll_ram.sv
rtl/static_linked_list_engine_core.sv
test/tb_static_linked_list_engine_core.sv
